### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg - shared types and constants for the bitmap page allocator
// Field widths, request and status codes, sequencer states and the flags
// passed from the bit unit to the controller.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Fixed field widths
  localparam int PAGE_W     = 40;
  localparam int CNT_W      = 13;
  localparam int KIND_W     = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int OUT_DATA_W = 56;

  // Request kinds (code 3 is unused and rejected)
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;

  // Register select: paddr bit 3 picks the register
  localparam logic REG_SEL_BASE  = 1'b0;
  localparam logic REG_SEL_COUNT = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOFREE  = 2'd1,
    STAT_OUTSIDE = 2'd2,
    STAT_SAME    = 2'd3
  } status_t;

  // Used-count update applied when a result is posted
  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_DIVQ,
    S_DIVR,
    S_TEST,
    S_SCAN,
    S_FIN
  } state_t;

  // Flags from the bit unit
  typedef struct packed {
    logic free_found;  // a free page below the limit exists in the word
    logic bit_set;     // selected bit is currently used
  } test_t;

endpackage

### src/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data. No reset on contents.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/bpa_bit_unit.sv
// ----------------------------------------------------------------------------
// bpa_bit_unit - shared bitmap word unit
// Finds the lowest free bit below a limit, tests one selected bit, and
// builds the word with one bit set or cleared.
// ----------------------------------------------------------------------------
module bpa_bit_unit #(
  parameter int WORD_BITS = 64,
  parameter int LIM_W     = 14
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [LIM_W-1:0]             lim,       // bits at or above are off limits
  input  logic [$clog2(WORD_BITS)-1:0] bit_sel,
  input  logic                         use_scan,  // modify the found bit, not bit_sel
  input  logic                         op_set,    // 1: set, 0: clear
  output bpa_pkg::test_t               flags,
  output logic [$clog2(WORD_BITS)-1:0] free_pos,
  output logic [WORD_BITS-1:0]         new_word
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] free_v;
  logic [BIT_W-1:0]     pos;
  logic [BIT_W-1:0]     sel_pos;
  logic [WORD_BITS-1:0] one_hot;

  // Free bits inside the limit
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      free_v[b] = ~word[b] & (LIM_W'(b) < lim);
    end
  end

  // Lowest free bit
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_v[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

  assign flags.free_found = |free_v;
  assign flags.bit_set    = word[bit_sel];
  assign free_pos         = pos;

  // Set or clear one bit
  assign sel_pos  = use_scan ? pos : bit_sel;
  assign one_hot  = WORD_BITS'(1) << sel_pos;
  assign new_word = op_set ? (word | one_hot) : (word & ~one_hot);

endmodule

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl - request sequencer for the bitmap page allocator
// Clears the bitmap after reset, then runs one request at a time: a
// word-by-word scan for allocate, or index split, test and update for
// reserve and free. Results go to an output register.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 64,
  parameter int NUM_WORDS = 64,
  parameter int WADDR_W   = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config
  input  logic [bpa_pkg::PAGE_W-1:0]     base_page,
  input  logic [bpa_pkg::CNT_W-1:0]      sect_pages,
  // request
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [bpa_pkg::KIND_W-1:0]     req_kind,
  input  logic [bpa_pkg::PAGE_W-1:0]     req_page,
  // result
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [bpa_pkg::PAGE_W-1:0]     res_page,
  output bpa_pkg::status_t               res_status,
  output logic [bpa_pkg::CNT_W-1:0]      res_count,
  // bitmap RAM
  output logic                           ram_we,
  output logic [WADDR_W-1:0]             ram_waddr,
  output logic [WORD_BITS-1:0]           ram_wdata,
  output logic [WADDR_W-1:0]             ram_raddr,
  input  logic [WORD_BITS-1:0]           ram_rdata
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int SZ_W   = ($clog2(MAX_PAGES + 1) > bpa_pkg::CNT_W) ?
                          $clog2(MAX_PAGES + 1) : bpa_pkg::CNT_W;
  localparam int BW     = SZ_W + 1;
  // index / WORD_BITS by reciprocal, exact for every IDX_W-bit index
  localparam int DIV_K  = IDX_W + BIT_W;
  localparam int RC_W   = DIV_K + 1;
  localparam int RECIP  = ((2 ** DIV_K) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = IDX_W + RC_W;

  bpa_pkg::state_t  state_r, state_nxt;

  logic [bpa_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [bpa_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [WADDR_W-1:0]         q_r, q_nxt;
  logic [BIT_W-1:0]           bit_r, bit_nxt;
  logic [WADDR_W-1:0]         clr_r, clr_nxt;
  logic [WADDR_W-1:0]         scan_w_r, scan_w_nxt;
  logic [BW-1:0]              scan_base_r, scan_base_nxt;
  logic [bpa_pkg::CNT_W-1:0]  used_cnt_r, used_cnt_nxt;

  // pending result and bitmap update
  logic [bpa_pkg::PAGE_W-1:0] pend_page_r, pend_page_nxt;
  bpa_pkg::status_t           pend_status_r, pend_status_nxt;
  logic                       pend_we_r, pend_we_nxt;
  logic [WADDR_W-1:0]         pend_addr_r, pend_addr_nxt;
  logic [WORD_BITS-1:0]       pend_word_r, pend_word_nxt;
  bpa_pkg::cnt_op_t           pend_cnt_r, pend_cnt_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [bpa_pkg::PAGE_W-1:0] out_page_r, out_page_nxt;
  bpa_pkg::status_t           out_status_r, out_status_nxt;
  logic [bpa_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [SZ_W-1:0]            size;
  logic [SZ_W-1:0]            cnt_ext;
  logic [bpa_pkg::PAGE_W-1:0] rel_idx;
  logic                       outside;
  logic [BW-1:0]              lim;
  logic [BW-1:0]              next_base;
  logic [PROD_W-1:0]          q_prod;
  logic [IDX_W-1:0]           q_times_w;
  logic [IDX_W-1:0]           rem_idx;
  logic                       fin_fire;
  logic                       op_set;
  bpa_pkg::test_t             flags;
  logic [BIT_W-1:0]           free_pos;
  logic [WORD_BITS-1:0]       new_word;

  // Effective section size and range check
  assign cnt_ext = SZ_W'(sect_pages);
  assign size    = (cnt_ext < SZ_W'(MAX_PAGES)) ? cnt_ext : SZ_W'(MAX_PAGES);
  assign rel_idx = page_r - base_page;
  assign outside = (page_r < base_page) ||
                   (rel_idx >= bpa_pkg::PAGE_W'(size));

  // Scan limits
  assign lim       = BW'(size) - scan_base_r;
  assign next_base = scan_base_r + BW'(WORD_BITS);

  // Index split: word = idx / WORD_BITS, bit = idx % WORD_BITS
  assign q_prod    = PROD_W'(idx_r) * PROD_W'(RECIP);
  assign q_times_w = IDX_W'(q_r) * IDX_W'(WORD_BITS);
  assign rem_idx   = idx_r - q_times_w;

  assign fin_fire = (state_r == bpa_pkg::S_FIN) && (!out_valid_r || res_ready);
  assign op_set   = (kind_r != bpa_pkg::KIND_FREE);

  bpa_bit_unit #(
    .WORD_BITS (WORD_BITS),
    .LIM_W     (BW)
  ) u_bit_unit (
    .word     (ram_rdata),
    .lim      (lim),
    .bit_sel  (bit_r),
    .use_scan (state_r == bpa_pkg::S_SCAN),
    .op_set   (op_set),
    .flags    (flags),
    .free_pos (free_pos),
    .new_word (new_word)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        if (clr_r == WADDR_W'(NUM_WORDS - 1)) begin
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (req_valid) begin
          state_nxt = bpa_pkg::S_CALC;
        end
      end
      bpa_pkg::S_CALC: begin
        priority if (kind_r == bpa_pkg::KIND_ALLOC) begin
          state_nxt = (SZ_W'(used_cnt_r) < size) ? bpa_pkg::S_SCAN : bpa_pkg::S_FIN;
        end else if ((kind_r == bpa_pkg::KIND_RESERVE || kind_r == bpa_pkg::KIND_FREE)
                     && !outside) begin
          state_nxt = bpa_pkg::S_DIVQ;
        end else begin
          state_nxt = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_DIVQ: state_nxt = bpa_pkg::S_DIVR;
      bpa_pkg::S_DIVR: state_nxt = bpa_pkg::S_TEST;
      bpa_pkg::S_TEST: state_nxt = bpa_pkg::S_FIN;
      bpa_pkg::S_SCAN: begin
        if (flags.free_found || next_base >= BW'(size)) begin
          state_nxt = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_FIN: begin
        if (fin_fire) begin
          state_nxt = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    kind_nxt        = kind_r;
    page_nxt        = page_r;
    idx_nxt         = idx_r;
    q_nxt           = q_r;
    bit_nxt         = bit_r;
    clr_nxt         = clr_r;
    scan_w_nxt      = scan_w_r;
    scan_base_nxt   = scan_base_r;
    used_cnt_nxt    = used_cnt_r;
    pend_page_nxt   = pend_page_r;
    pend_status_nxt = pend_status_r;
    pend_we_nxt     = pend_we_r;
    pend_addr_nxt   = pend_addr_r;
    pend_word_nxt   = pend_word_r;
    pend_cnt_nxt    = pend_cnt_r;
    out_page_nxt    = out_page_r;
    out_status_nxt  = out_status_r;
    out_cnt_nxt     = out_cnt_r;
    out_valid_nxt   = out_valid_r && !res_ready;
    req_ready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = clr_r;
    ram_wdata       = '0;
    ram_raddr       = '0;

    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + WADDR_W'(1);
      end
      bpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          kind_nxt = req_kind;
          page_nxt = req_page;
        end
      end
      bpa_pkg::S_CALC: begin
        // defaults for the early-exit cases
        pend_we_nxt     = 1'b0;
        pend_cnt_nxt    = bpa_pkg::CNT_KEEP;
        pend_page_nxt   = page_r;
        pend_status_nxt = bpa_pkg::STAT_OUTSIDE;
        idx_nxt         = rel_idx[IDX_W-1:0];
        scan_w_nxt      = '0;
        scan_base_nxt   = '0;
        if (kind_r == bpa_pkg::KIND_ALLOC) begin
          pend_page_nxt   = '0;
          pend_status_nxt = bpa_pkg::STAT_NOFREE;
        end
      end
      bpa_pkg::S_DIVQ: begin
        q_nxt = q_prod[DIV_K +: WADDR_W];
      end
      bpa_pkg::S_DIVR: begin
        bit_nxt   = rem_idx[BIT_W-1:0];
        ram_raddr = q_r;
      end
      bpa_pkg::S_TEST: begin
        pend_addr_nxt = q_r;
        pend_word_nxt = new_word;
        if (flags.bit_set == op_set) begin
          pend_status_nxt = bpa_pkg::STAT_SAME;
        end else begin
          pend_status_nxt = bpa_pkg::STAT_DONE;
          pend_we_nxt     = 1'b1;
          pend_cnt_nxt    = op_set ? bpa_pkg::CNT_INC : bpa_pkg::CNT_DEC;
        end
      end
      bpa_pkg::S_SCAN: begin
        // read data holds word scan_w_r; fetch the next one meanwhile
        ram_raddr     = scan_w_r + WADDR_W'(1);
        scan_w_nxt    = scan_w_r + WADDR_W'(1);
        scan_base_nxt = next_base;
        if (flags.free_found) begin
          pend_status_nxt = bpa_pkg::STAT_DONE;
          pend_page_nxt   = base_page + bpa_pkg::PAGE_W'(scan_base_r + BW'(free_pos));
          pend_we_nxt     = 1'b1;
          pend_addr_nxt   = scan_w_r;
          pend_word_nxt   = new_word;
          pend_cnt_nxt    = bpa_pkg::CNT_INC;
        end
      end
      bpa_pkg::S_FIN: begin
        if (fin_fire) begin
          ram_we    = pend_we_r;
          ram_waddr = pend_addr_r;
          ram_wdata = pend_word_r;
          unique case (pend_cnt_r)
            bpa_pkg::CNT_INC: used_cnt_nxt = used_cnt_r + bpa_pkg::CNT_W'(1);
            bpa_pkg::CNT_DEC: begin
              if (used_cnt_r != '0) begin
                used_cnt_nxt = used_cnt_r - bpa_pkg::CNT_W'(1);
              end
            end
            default: used_cnt_nxt = used_cnt_r;
          endcase
          out_valid_nxt  = 1'b1;
          out_page_nxt   = pend_page_r;
          out_status_nxt = pend_status_r;
          out_cnt_nxt    = used_cnt_nxt;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      clr_r       <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      pend_we_r   <= 1'b0;
      pend_cnt_r  <= bpa_pkg::CNT_KEEP;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_we_r   <= pend_we_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    page_r        <= page_nxt;
    idx_r         <= idx_nxt;
    q_r           <= q_nxt;
    bit_r         <= bit_nxt;
    scan_w_r      <= scan_w_nxt;
    scan_base_r   <= scan_base_nxt;
    pend_page_r   <= pend_page_nxt;
    pend_status_r <= pend_status_nxt;
    pend_addr_r   <= pend_addr_nxt;
    pend_word_r   <= pend_word_nxt;
    out_page_r    <= out_page_nxt;
    out_status_r  <= out_status_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  assign res_valid  = out_valid_r;
  assign res_page   = out_page_r;
  assign res_status = out_status_r;
  assign res_count  = out_cnt_r;

endmodule

### src/bitmap_page_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top - bitmap page-frame allocator
// Allocates, reserves and frees pages of one physical section using a
// used-bit bitmap held in RAM, with an APB-style register port.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+---------------------------------
//   in_      | in  | tvalid/tready        | tuser: kind; tdata: page
//   out_     | out | tvalid/tready        | tdata: page_out, status, used_count
//   cfg_     | in  | psel/penable/pready  | base_page @0x0, sect_pages @0x8
//
// After reset the bitmap RAM is cleared one word per cycle, all NUM_WORDS
// words (64 at the default sizes), during which in_tready stays low.
// Allocate scans the bitmap word by word (up to MAX_PAGES/WORD_BITS words),
// paced by the single RAM read port feeding the bit unit. Reserve and free
// run a range check, two index-split steps, a read and an update; a rejected
// request or an allocate on a full section goes from the range check straight
// to the final step. Each request returns to idle, where the next word is
// taken. One request is in flight at a time; the next word is accepted while
// the previous result waits in the output register, but a request holds at
// its final step while that result is still unread.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top #(
  parameter int MAX_PAGES = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [39:0]                        in_tdata,   // [39:0] page
  input  logic [1:0]                         in_tuser,   // [1:0] kind
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0]     out_tdata,  // [39:0] page_out,
                                                         // [41:40] status,
                                                         // [54:42] used_count
  // register port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bpa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [bpa_pkg::PAGE_W-1:0] base_page_r;
  logic [bpa_pkg::CNT_W-1:0]  sect_pages_r;
  logic                       cfg_wr;

  logic                       ram_we;
  logic [WADDR_W-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]       ram_wdata;
  logic [WADDR_W-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]       ram_rdata;

  logic [bpa_pkg::PAGE_W-1:0] res_page;
  bpa_pkg::status_t           res_status;
  logic [bpa_pkg::CNT_W-1:0]  res_count;

  // Register port: bit 3 of the address picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_page_r  <= '0;
      sect_pages_r <= bpa_pkg::CNT_W'(4096);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        bpa_pkg::REG_SEL_BASE:  base_page_r  <= cfg_pwdata[bpa_pkg::PAGE_W-1:0];
        bpa_pkg::REG_SEL_COUNT: sect_pages_r <= cfg_pwdata[bpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == bpa_pkg::REG_SEL_COUNT) ?
                      bpa_pkg::CFG_DATA_W'(sect_pages_r) :
                      bpa_pkg::CFG_DATA_W'(base_page_r);

  // Bitmap storage
  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer
  bpa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .WADDR_W   (WADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_page  (base_page_r),
    .sect_pages (sect_pages_r),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_kind   (in_tuser),
    .req_page   (in_tdata),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_page   (res_page),
    .res_status (res_status),
    .res_count  (res_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Result word, padded to whole bytes
  assign out_tdata = {1'b0, res_count, res_status, res_page};

endmodule

### tb/sv/bitmap_page_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top_tb - self-checking bench for the page allocator
// A directed table walks allocate, reserve, free and the unused kind through
// full, shrunk, oversized, empty and wrapping sections. Random phases follow
// with new register settings. Every result word is checked against the table's
// expected result or an in-bench model of the used-page bitmap, and each register is read back.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              MAX_PAGES   = 4096;
  localparam int              WORD_BITS   = 64;
  localparam int              NUM_WORDS   = MAX_PAGES / WORD_BITS;
  localparam logic [1:0]      KIND_UNUSED = 2'd3;
  localparam logic [39:0]     PAGE_TOP    = 40'hFF_FFFF_FFFF;
  localparam logic [39:0]     PAGE_WRAP   = 40'hFF_FFFF_FFFE;

  typedef struct packed {
    logic [39:0]      page;
    bpa_pkg::status_t status;
    logic [12:0]      used;
  } page_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_BASE, ROW_COUNT} row_op_t;

  typedef struct packed {
    row_op_t      op;
    logic [1:0]   kind;
    logic [39:0]  value;   // request page, or register value
    logic         typed;   // want holds the expected result
    page_result_t want;
  } plan_row_t;

  localparam page_result_t NO_RES = '{40'd0, bpa_pkg::STAT_DONE, 13'd0};

  // Directed table: low pages, section edges, shrink/grow, wrap, empty section
  localparam int PLAN_LEN = 34;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_DONE, 13'd1}},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, PAGE_TOP, 1'b1,
      '{40'd1, bpa_pkg::STAT_DONE, 13'd2}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_SAME, 13'd2}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, 40'd5, 1'b1,
      '{40'd5, bpa_pkg::STAT_SAME, 13'd2}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd4095, 1'b1,
      '{40'd4095, bpa_pkg::STAT_DONE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd4096, 1'b1,
      '{40'd4096, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, PAGE_TOP, 1'b1,
      '{PAGE_TOP, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    '{ROW_REQ, KIND_UNUSED, 40'hAA_AAAA_AAAA, 1'b1,
      '{40'hAA_AAAA_AAAA, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_DONE, 13'd2}},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_DONE, 13'd3}},
    // oversized count clips to the bitmap size
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd8191, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd4096, 1'b1,
      '{40'd4096, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd2, bpa_pkg::STAT_DONE, 13'd4}},
    // shrunk count: page 4095 stays counted but is out of reach
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd2, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_NOFREE, 13'd4}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, 40'd4095, 1'b1,
      '{40'd4095, bpa_pkg::STAT_OUTSIDE, 13'd4}},
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd4096, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_FREE, 40'd4095, 1'b1,
      '{40'd4095, bpa_pkg::STAT_DONE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, 40'd2, 1'b1,
      '{40'd2, bpa_pkg::STAT_DONE, 13'd2}},
    // fill a tiny section
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd3, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd2, bpa_pkg::STAT_DONE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_NOFREE, 13'd3}},
    // base near the top: allocated address wraps
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd4096, 1'b0, NO_RES},
    '{ROW_BASE, bpa_pkg::KIND_ALLOC, PAGE_WRAP, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd1, bpa_pkg::STAT_DONE, 13'd4}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, PAGE_TOP, 1'b1,
      '{PAGE_TOP, bpa_pkg::STAT_SAME, 13'd4}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_OUTSIDE, 13'd4}},
    '{ROW_REQ, bpa_pkg::KIND_FREE, PAGE_WRAP, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, 40'd4093, 1'b1,
      '{40'd4093, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    // empty section
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd0, 1'b0, NO_RES},
    '{ROW_REQ, bpa_pkg::KIND_ALLOC, 40'd0, 1'b1,
      '{40'd0, bpa_pkg::STAT_NOFREE, 13'd3}},
    '{ROW_REQ, bpa_pkg::KIND_RESERVE, PAGE_WRAP, 1'b1,
      '{PAGE_WRAP, bpa_pkg::STAT_OUTSIDE, 13'd3}},
    '{ROW_BASE, bpa_pkg::KIND_ALLOC, 40'd0, 1'b0, NO_RES},
    '{ROW_COUNT, bpa_pkg::KIND_ALLOC, 40'd4096, 1'b0, NO_RES}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [39:0]                     in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bpa_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [bpa_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  bitmap_page_allocator_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allocator mirror: used bitmap, count and the two registers
  bit [WORD_BITS-1:0] used_words [NUM_WORDS];
  logic [12:0]        used_total = '0;
  logic [39:0]        sect_base = '0;
  logic [12:0]        sect_count = 13'd4096;

  page_result_t pending_results [$];
  int           result_errors = 0;
  int           reg_errors = 0;
  int           burst_left = 0;

  function automatic int unsigned section_size();
    return (sect_count > 13'(MAX_PAGES)) ? MAX_PAGES : int'(sect_count);
  endfunction

  function automatic page_result_t allocate_or_update(input logic [1:0] kind,
                                                      input logic [39:0] page);
    page_result_t r;
    int unsigned  size;
    int unsigned  idx;
    logic [39:0]  offs;
    bit           found;
    size     = section_size();
    r.page   = page;
    r.status = bpa_pkg::STAT_DONE;
    unique case (kind)
      bpa_pkg::KIND_ALLOC: begin
        r.page = '0;
        found  = 1'b0;
        idx    = 0;
        if (used_total < 13'(size)) begin
          while (!found && idx < size) begin
            if (!used_words[idx / WORD_BITS][idx % WORD_BITS]) found = 1'b1;
            else idx++;
          end
        end
        if (found) begin
          used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
          used_total++;
          r.page = sect_base + 40'(idx);
        end else begin
          r.status = bpa_pkg::STAT_NOFREE;
        end
      end
      bpa_pkg::KIND_RESERVE, bpa_pkg::KIND_FREE: begin
        offs = page - sect_base;
        if (page < sect_base || offs >= 40'(size)) begin
          r.status = bpa_pkg::STAT_OUTSIDE;
        end else if (kind == bpa_pkg::KIND_RESERVE) begin
          if (used_words[offs[11:6]][offs[5:0]]) begin
            r.status = bpa_pkg::STAT_SAME;
          end else begin
            used_words[offs[11:6]][offs[5:0]] = 1'b1;
            used_total++;
          end
        end else begin
          if (!used_words[offs[11:6]][offs[5:0]]) begin
            r.status = bpa_pkg::STAT_SAME;
          end else begin
            used_words[offs[11:6]][offs[5:0]] = 1'b0;
            if (used_total != 0) used_total--;
          end
        end
      end
      default: r.status = bpa_pkg::STAT_OUTSIDE;
    endcase
    r.used = used_total;
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  // Mostly pages at the low end of the section, some at its edges and around
  function automatic logic [39:0] pick_page();
    int unsigned size;
    int unsigned lim;
    int unsigned r;
    size = section_size();
    lim  = (size < 96) ? size : 96;
    r    = $urandom_range(0, 99);
    if (r < 70) return sect_base + 40'($urandom_range(0, lim));
    if (r < 85) return sect_base + 40'($urandom_range(0, size + 1));
    if (r < 90) return sect_base - 40'($urandom_range(1, 4));
    return rand40();
  endfunction

  // Send one request word and queue its expected result
  task automatic issue_request(input logic [1:0] kind, input logic [39:0] page,
                               input logic typed, input page_result_t want);
    page_result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= page;
    do @(posedge clk); while (!in_tready);
    r = allocate_or_update(kind, page);
    if (typed) r = want;
    pending_results.push_back(r);
  endtask

  // Bursts of back-to-back words with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, then read back
  task automatic write_reg(input logic sel, input logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == bpa_pkg::REG_SEL_BASE) sect_base = value[39:0];
    else sect_count = value[12:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== value) begin
      $display("%0t readback addr %h expected %h got %h", $time, {sel, 3'b000},
               value, cfg_prdata);
      reg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result side: stall pattern and check against the oldest expectation
  int unsigned  rx_tick = 0;
  int unsigned  rx_period = 4;
  int unsigned  rx_hold = 0;
  page_result_t rx_want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word, expected none got %h", $time, out_tdata);
        result_errors++;
      end else begin
        rx_want = pending_results.pop_front();
        if (out_tdata[39:0] !== rx_want.page) begin
          $display("%0t page_out expected %h got %h", $time, rx_want.page,
                   out_tdata[39:0]);
          result_errors++;
        end
        if (out_tdata[41:40] !== rx_want.status) begin
          $display("%0t status expected %0d got %0d", $time, rx_want.status,
                   out_tdata[41:40]);
          result_errors++;
        end
        if (out_tdata[54:42] !== rx_want.used) begin
          $display("%0t used_count expected %0d got %0d", $time, rx_want.used,
                   out_tdata[54:42]);
          result_errors++;
        end
      end
    end
    rx_tick = rx_tick + 1;
    if (rx_tick >= rx_period) begin
      rx_tick   = 0;
      rx_period = $urandom_range(1, 16);
      rx_hold   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, rx_period - 1);
    end
    out_tready <= (rx_tick >= rx_hold);
  end

  // Stimulus
  initial begin
    logic [39:0] ph_base [8];
    logic [12:0] ph_count [8];
    int unsigned r;
    logic [1:0]  kind;
    logic [39:0] page;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (PLAN[i].op)
        ROW_REQ: begin
          issue_request(PLAN[i].kind, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
          pace_sender();
        end
        ROW_BASE: begin
          wait_drain();
          write_reg(bpa_pkg::REG_SEL_BASE, {24'd0, PLAN[i].value});
        end
        default: begin
          wait_drain();
          write_reg(bpa_pkg::REG_SEL_COUNT, {51'd0, PLAN[i].value[12:0]});
        end
      endcase
    end

    // random phases, each with its own section
    ph_base  = '{40'd0, PAGE_TOP, rand40(), 40'h80_0000_0000, 40'd0,
                 40'hFF_FFFF_FF80, rand40(), 40'd0};
    ph_count = '{13'd4096, 13'd8, 13'd64, 13'd8191, 13'd0, 13'd130,
                 13'($urandom_range(0, 8191)), 13'd1};
    for (int ph = 0; ph < 8; ph++) begin
      wait_drain();
      write_reg(bpa_pkg::REG_SEL_BASE, {24'd0, ph_base[ph]});
      write_reg(bpa_pkg::REG_SEL_COUNT, {51'd0, ph_count[ph]});
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          kind = bpa_pkg::KIND_ALLOC;
          page = rand40();
        end else if (r < 70) begin
          kind = bpa_pkg::KIND_FREE;
          page = pick_page();
        end else if (r < 93) begin
          kind = bpa_pkg::KIND_RESERVE;
          page = pick_page();
        end else begin
          kind = KIND_UNUSED;
          page = rand40();
        end
        issue_request(kind, page, 1'b0, NO_RES);
        // now and then hold off until the block has emptied
        if ($urandom_range(0, 79) == 0) wait_drain();
        else pace_sender();
      end
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (result_errors == 0 && reg_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_500_000;
    $display("Verification failed");
    $finish;
  end

endmodule
